[hw/rtl/triv_pkg.sv]
// shared types and constants for the trivium keystream generator
// no dependencies

package triv_pkg;

    localparam int STATE_BITS    = 288;
    localparam int KEY_BITS      = 80;
    localparam int IV_BASE       = 93;
    localparam int WORD_W        = 64;
    localparam int BITS_W        = 7;
    localparam int CNT_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int OUT_TDATA_W   = 72;
    localparam int IN_TDATA_W    = 8;

    localparam logic [CNT_W-1:0]  WARMUP_ROUNDS = 11'd1152;
    localparam logic [BITS_W-1:0] MAX_WORD_BITS = 7'd64;
    localparam logic [CNT_W-1:0]  WORD_CYCLES   = 11'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd3;

    localparam logic REQ_RESTART  = 1'b0;
    localparam logic REQ_GENERATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WARM,
        ST_GEN,
        ST_DONE
    } t_fsm;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
        logic clear;
        logic out_load;
    } t_ctl;

endpackage

[hw/rtl/triv_state.sv]
// 288-bit trivium state with key/iv registers, one round per step
// depends on triv_pkg

module triv_state
    import triv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data,
    input  t_ctl                  i_ctl,
    output logic                  o_z
);

    logic [WORD_W-1:0]     r_key_low;
    logic [15:0]           r_key_high;
    logic [WORD_W-1:0]     r_iv_low;
    logic [15:0]           r_iv_high;
    logic [STATE_BITS-1:0] r_s;
    logic [STATE_BITS-1:0] n_s;
    logic [STATE_BITS-1:0] w_init;
    logic                  w_a;
    logic                  w_b;
    logic                  w_c;
    logic                  w_ta;
    logic                  w_tb;
    logic                  w_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv_low   <= '0;
            r_iv_high  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data[15:0];
                CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                CFG_IV_HIGH:  r_iv_high  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // key in bits 0..79, iv in 93..172, ones in 285..287
    assign w_init = {3'b111, 112'd0, r_iv_high, r_iv_low, 13'd0, r_key_high, r_key_low};

    assign w_ta = r_s[65] ^ r_s[92];
    assign w_tb = r_s[161] ^ r_s[176];
    assign w_tc = r_s[242] ^ r_s[287];
    assign o_z  = w_ta ^ w_tb ^ w_tc;
    assign w_a  = w_ta ^ (r_s[90] & r_s[91]) ^ r_s[170];
    assign w_b  = w_tb ^ (r_s[174] & r_s[175]) ^ r_s[263];
    assign w_c  = w_tc ^ (r_s[285] & r_s[286]) ^ r_s[68];

    always_comb begin
        n_s = r_s;
        if (i_ctl.load) begin
            n_s = w_init;
        end else if (i_ctl.step) begin
            n_s = {r_s[286:177], w_b, r_s[175:93], w_a, r_s[91:0], w_c};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else begin
            r_s <= n_s;
        end
    end

endmodule

[hw/rtl/triv_pack.sv]
// serial packer: shifts keystream bits into a word, then output register
// depends on triv_pkg

module triv_pack
    import triv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl                   i_ctl,
    input  logic                   i_z,
    input  logic [BITS_W-1:0]      i_bits,
    output logic                   o_out_free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [WORD_W-1:0]      r_word;
    logic [WORD_W-1:0]      n_word;
    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic                   w_bit;

    assign w_bit = i_ctl.step & i_z;

    always_comb begin
        n_word = r_word;
        if (i_ctl.clear) begin
            n_word = '0;
        end else if (i_ctl.shift) begin
            n_word = {w_bit, r_word[WORD_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_data <= {1'b0, i_bits, r_word};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

[hw/rtl/triv_ctrl.sv]
// request sequencer: warm-up and generate round counting
// depends on triv_pkg

module triv_ctrl
    import triv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  i_out_free,
    output t_ctl                  o_ctl,
    output logic [BITS_W-1:0]     o_bits
);

    t_fsm              r_state;
    t_fsm              n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [BITS_W-1:0] r_bits;
    logic [BITS_W-1:0] n_bits;
    logic [BITS_W-1:0] w_req_bits;
    logic              w_accept;

    assign w_accept = s_axis_tvalid && (r_state == ST_IDLE);

    always_comb begin
        w_req_bits = s_axis_tdata[BITS_W-1:0];
        if (w_req_bits == '0) begin
            w_req_bits = 7'd1;
        end else if (w_req_bits > MAX_WORD_BITS) begin
            w_req_bits = MAX_WORD_BITS;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    if (s_axis_tuser == REQ_RESTART) begin
                        n_bits  = '0;
                        n_state = ST_WARM;
                    end else begin
                        n_bits  = w_req_bits;
                        n_state = ST_GEN;
                    end
                end
            end
            ST_WARM: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WARMUP_ROUNDS - 1'b1) begin
                    n_state = ST_DONE;
                end
            end
            ST_GEN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WORD_CYCLES - 1'b1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl          = '0;
        o_ctl.load     = w_accept && (s_axis_tuser == REQ_RESTART);
        o_ctl.clear    = w_accept;
        o_ctl.step     = (r_state == ST_WARM) ||
                         ((r_state == ST_GEN) &&
                          (r_cnt < {{(CNT_W-BITS_W){1'b0}}, r_bits}));
        o_ctl.shift    = (r_state == ST_GEN);
        o_ctl.out_load = (r_state == ST_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_bits        = r_bits;

endmodule

[hw/rtl/trivium_keystream_generator_core.sv]
// trivium keystream generator, top level: one round per cycle in warm-up or a generate step
// generate: bits shift in during ST_GEN, then load into the output register once it is free
// restart: load key/iv, then 1152 warm-up rounds, then the result is registered
// one request at a time: the next is taken once the result is registered
// synchronous active-low reset clears the state, the key/iv registers and control
// depends on triv_pkg, triv_state, triv_pack, triv_ctrl

module trivium_keystream_generator_core
    import triv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // bit_count[6:0], zero pad
    input  logic                   s_axis_tuser,  // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // keystream_word[63:0], word_bits[70:64], pad
);

    t_ctl              w_ctl;
    logic [BITS_W-1:0] w_bits;
    logic              w_z;
    logic              w_out_free;

    triv_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_out_free    (w_out_free),
        .o_ctl         (w_ctl),
        .o_bits        (w_bits)
    );

    triv_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .o_z         (w_z)
    );

    triv_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_z           (w_z),
        .i_bits        (w_bits),
        .o_out_free    (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
